// ----- src/clock_set_stopwatch_mode_control_macros.svh -----
// Assertion macros shared by the mode controller RTL.
`ifndef CLOCK_SET_STOPWATCH_MODE_CONTROL_MACROS_SVH
`define CLOCK_SET_STOPWATCH_MODE_CONTROL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/csm_pkg.sv -----
// Package with types, codes and helper functions of the clock mode controller.
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

	// Operating modes.
	typedef enum logic [1:0] {
		MODE_DISPLAY   = 2'd0,
		MODE_SET       = 2'd1,
		MODE_STOPWATCH = 2'd2
	} mode_t;

	// Event codes.
	localparam logic [2:0] OP_LEFT_CLICK  = 3'd0;
	localparam logic [2:0] OP_RIGHT_CLICK = 3'd1;
	localparam logic [2:0] OP_LEFT_HOLD   = 3'd2;
	localparam logic [2:0] OP_RIGHT_HOLD  = 3'd3;
	localparam logic [2:0] OP_BOTH_HOLD   = 3'd4;
	localparam logic [2:0] OP_FACE        = 3'd5;

	// Set cursor positions.
	localparam logic [1:0] CUR_HOURS        = 2'd0;
	localparam logic [1:0] CUR_TENS_MINUTES = 2'd1;
	localparam logic [1:0] CUR_MINUTES      = 2'd2;

	// Faces with a meaning of their own.
	localparam logic [2:0] FACE_UNKNOWN   = 3'd0;
	localparam logic [2:0] FACE_DEFAULT   = 3'd1;
	localparam logic [2:0] FACE_ROT270    = 3'd2;
	localparam logic [2:0] FACE_STOPWATCH = 3'd3;
	localparam logic [2:0] FACE_ROT90     = 3'd5;

	// Screen rotation codes.
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_90   = 2'd1;
	localparam logic [1:0] ROT_180  = 2'd2;
	localparam logic [1:0] ROT_270  = 2'd3;

	// Reciprocal of 60 scaled by 2^37, exact quotient for every 32-bit dividend.
	localparam logic [31:0] RECIP60 = 32'h8888_8889;
	localparam int unsigned RECIP60_SHIFT = 37;

	// One input event.
	typedef struct packed {
		logic [2:0]  opcode;
		logic [4:0]  cur_hours;
		logic [5:0]  cur_minutes;
		logic [2:0]  face;
		logic [31:0] now_seconds;
	} csm_in_t;

	// One result.
	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  cursor_pos;
		logic        show_seconds;
		logic        show_temperature;
		logic        show_voltage;
		logic        time_write;
		logic [4:0]  new_hours;
		logic [5:0]  new_minutes;
		logic [26:0] elapsed_minutes;
		logic [5:0]  elapsed_secs;
		logic [1:0]  rotation;
	} csm_out_t;

	// Modulo 24 of a value below 72.
	function automatic logic [4:0] mod24(input logic [6:0] v);
		logic [6:0] r;
		begin
			r = v;
			if (r >= 7'd48) begin
				r = r - 7'd48;
			end else if (r >= 7'd24) begin
				r = r - 7'd24;
			end
			mod24 = r[4:0];
		end
	endfunction

	// Modulo 60 of a value below 180.
	function automatic logic [5:0] mod60(input logic [7:0] v);
		logic [7:0] r;
		begin
			r = v;
			if (r >= 8'd120) begin
				r = r - 8'd120;
			end else if (r >= 8'd60) begin
				r = r - 8'd60;
			end
			mod60 = r[5:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- src/csm_stream_if.sv -----
// Valid/ready stream interface carrying one payload type.
`timescale 1ns / 1ps
`default_nettype none

interface csm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/clock_set_stopwatch_mode_control.sv -----
// Top level of the two-button clock mode controller with set mode and stopwatch.
//
// Channel  Direction  Payload               Transfer
// req      sink       csm_pkg::csm_in_t     req.valid && req.ready
// rsp      source     csm_pkg::csm_out_t    rsp.valid && rsp.ready
//
// Every event gives one result; after its transfer it passes the input register,
// mode update, reciprocal multiply for the divide by 60, remainder and result register.
// One event per cycle unless rsp stalls; the state is updated as an event leaves stage one.
// Reset (arst_n low) clears the mode state and empties all stages at once.
// A stalled result holds the pipe; each stage still fills while the stage after it is free.
`timescale 1ns / 1ps
`default_nettype none

`include "clock_set_stopwatch_mode_control_macros.svh"

module clock_set_stopwatch_mode_control (
	input  wire logic     clk,
	input  wire logic     arst_n,
	csm_stream_if.sink    req,
	csm_stream_if.source  rsp
);

	// Stage registers.
	csm_pkg::csm_in_t  req_s1;
	logic              v_s1;
	csm_pkg::csm_out_t res_s2;
	logic [31:0]       diff_s2;
	logic              v_s2;
	csm_pkg::csm_out_t res_s3;
	logic [26:0]       quo_s3;
	logic [5:0]        dlow_s3;
	logic              v_s3;
	csm_pkg::csm_out_t res_s4;
	logic              v_s4;

	// Mode state.
	csm_pkg::mode_t mode_q;
	logic [1:0]     cursor_q;
	logic           sec_flag_q;
	logic           temp_flag_q;
	logic           volt_flag_q;
	logic [2:0]     cur_face_q;
	logic [2:0]     prev_face_q;
	logic [31:0]    start_q;

	// Next state and stage-one result.
	csm_pkg::mode_t    mode_n;
	logic [1:0]        cursor_n;
	logic              sec_flag_n;
	logic              temp_flag_n;
	logic              volt_flag_n;
	logic [2:0]        cur_face_n;
	logic [2:0]        prev_face_n;
	logic [31:0]       start_n;
	csm_pkg::csm_out_t res_c1;
	logic [31:0]       diff_c1;
	logic              up;

	// Multiply and remainder.
	logic [63:0]       prod_c2;
	logic [5:0]        rem_c3;
	csm_pkg::csm_out_t res_c3;

	// Stage load enables: a stage loads when it is empty or its item moves on.
	logic ld1, ld2, ld3, ld4;

	assign ld4 = !v_s4 || rsp.ready;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	assign req.ready = ld1;
	assign rsp.valid = v_s4;
	assign rsp.data  = res_s4;

	// Mode, cursor, toggles and the result fields of stage one.
	always_comb begin
		mode_n      = mode_q;
		cursor_n    = cursor_q;
		sec_flag_n  = sec_flag_q;
		temp_flag_n = temp_flag_q;
		volt_flag_n = volt_flag_q;
		cur_face_n  = cur_face_q;
		prev_face_n = prev_face_q;
		start_n     = start_q;
		res_c1      = '0;
		diff_c1     = '0;
		up          = (req_s1.opcode == csm_pkg::OP_RIGHT_CLICK);

		case (req_s1.opcode)
			csm_pkg::OP_LEFT_CLICK, csm_pkg::OP_RIGHT_CLICK: begin
				if (mode_q == csm_pkg::MODE_SET) begin
					case (cursor_q)
						csm_pkg::CUR_HOURS: begin
							res_c1.time_write  = 1'b1;
							res_c1.new_minutes = req_s1.cur_minutes;
							res_c1.new_hours   = csm_pkg::mod24(up ?
								{2'b00, req_s1.cur_hours} + 7'd1 :
								{2'b00, req_s1.cur_hours} + 7'd23);
						end
						csm_pkg::CUR_TENS_MINUTES: begin
							res_c1.time_write  = 1'b1;
							res_c1.new_hours   = req_s1.cur_hours;
							res_c1.new_minutes = csm_pkg::mod60(up ?
								{2'b00, req_s1.cur_minutes} + 8'd10 :
								{2'b00, req_s1.cur_minutes} + 8'd50);
						end
						csm_pkg::CUR_MINUTES: begin
							res_c1.time_write  = 1'b1;
							res_c1.new_hours   = req_s1.cur_hours;
							res_c1.new_minutes = csm_pkg::mod60(up ?
								{2'b00, req_s1.cur_minutes} + 8'd1 :
								{2'b00, req_s1.cur_minutes} + 8'd59);
						end
						default: begin
						end
					endcase
				end else if (mode_q == csm_pkg::MODE_DISPLAY) begin
					if (up) begin
						volt_flag_n = !volt_flag_q;
					end else begin
						temp_flag_n = !temp_flag_q;
					end
				end
			end
			csm_pkg::OP_LEFT_HOLD: begin
				if (mode_q == csm_pkg::MODE_DISPLAY) begin
					mode_n   = csm_pkg::MODE_SET;
					cursor_n = csm_pkg::CUR_MINUTES;
				end else if (mode_q == csm_pkg::MODE_SET) begin
					if (cursor_q == csm_pkg::CUR_HOURS) begin
						mode_n = csm_pkg::MODE_DISPLAY;
					end else begin
						cursor_n = cursor_q - 2'd1;
					end
				end
			end
			csm_pkg::OP_RIGHT_HOLD: begin
				if (mode_q == csm_pkg::MODE_DISPLAY) begin
					mode_n   = csm_pkg::MODE_SET;
					cursor_n = csm_pkg::CUR_HOURS;
				end else if (mode_q == csm_pkg::MODE_SET) begin
					if (cursor_q >= csm_pkg::CUR_MINUTES) begin
						mode_n = csm_pkg::MODE_DISPLAY;
					end else begin
						cursor_n = cursor_q + 2'd1;
					end
				end
			end
			csm_pkg::OP_BOTH_HOLD: begin
				sec_flag_n = !sec_flag_q;
			end
			csm_pkg::OP_FACE: begin
				cur_face_n = req_s1.face;
				if (req_s1.face != prev_face_q) begin
					prev_face_n = req_s1.face;
					if (mode_q == csm_pkg::MODE_DISPLAY &&
						req_s1.face == csm_pkg::FACE_STOPWATCH) begin
						mode_n  = csm_pkg::MODE_STOPWATCH;
						start_n = req_s1.now_seconds;
					end else if (mode_q == csm_pkg::MODE_STOPWATCH &&
						req_s1.face != csm_pkg::FACE_STOPWATCH) begin
						mode_n = csm_pkg::MODE_DISPLAY;
					end
				end
			end
			default: begin
			end
		endcase

		// Rotation and elapsed time follow the updated state.
		res_c1.rotation = csm_pkg::ROT_NONE;
		if (mode_n == csm_pkg::MODE_STOPWATCH) begin
			diff_c1         = req_s1.now_seconds - start_n;
			res_c1.rotation = csm_pkg::ROT_180;
		end else if (mode_n == csm_pkg::MODE_DISPLAY) begin
			if (cur_face_n == csm_pkg::FACE_ROT270) begin
				res_c1.rotation = csm_pkg::ROT_270;
			end else if (cur_face_n == csm_pkg::FACE_ROT90) begin
				res_c1.rotation = csm_pkg::ROT_90;
			end
		end

		res_c1.mode             = mode_n;
		res_c1.cursor_pos       = cursor_n;
		res_c1.show_seconds     = sec_flag_n;
		res_c1.show_temperature = temp_flag_n;
		res_c1.show_voltage     = volt_flag_n;
	end

	// Quotient by 60 through the scaled reciprocal.
	assign prod_c2 = 64'(diff_s2) * 64'(csm_pkg::RECIP60);

	// The remainder is below 64, so six bits suffice: d - 60q = d + 4q mod 64.
	assign rem_c3 = dlow_s3 + {quo_s3[3:0], 2'b00};

	// Final result with the elapsed time filled in.
	always_comb begin
		res_c3                 = res_s3;
		res_c3.elapsed_minutes = quo_s3;
		res_c3.elapsed_secs    = rem_c3;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= req.valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (ld1) begin
			req_s1 <= req.data;
		end
		if (ld2) begin
			res_s2  <= res_c1;
			diff_s2 <= diff_c1;
		end
		if (ld3) begin
			res_s3  <= res_s2;
			quo_s3  <= prod_c2[csm_pkg::RECIP60_SHIFT +: 27];
			dlow_s3 <= diff_s2[5:0];
		end
		if (ld4) begin
			res_s4 <= res_c3;
		end
	end

	// Mode state, updated as an event moves from stage one to stage two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= csm_pkg::MODE_DISPLAY;
			cursor_q    <= csm_pkg::CUR_HOURS;
			sec_flag_q  <= 1'b0;
			temp_flag_q <= 1'b0;
			volt_flag_q <= 1'b0;
			cur_face_q  <= csm_pkg::FACE_DEFAULT;
			prev_face_q <= csm_pkg::FACE_UNKNOWN;
			start_q     <= '0;
		end else if (v_s1 && ld2) begin
			mode_q      <= mode_n;
			cursor_q    <= cursor_n;
			sec_flag_q  <= sec_flag_n;
			temp_flag_q <= temp_flag_n;
			volt_flag_q <= volt_flag_n;
			cur_face_q  <= cur_face_n;
			prev_face_q <= prev_face_n;
			start_q     <= start_n;
		end
	end

	// Checks on the controller.
	`CSM_ASSERT_IMPLY(a_cursor_range, clk, arst_n, mode_q == csm_pkg::MODE_SET,
		cursor_q != 2'd3, "set cursor left its range")
	`CSM_ASSERT_IMPLY(a_write_in_set, clk, arst_n, rsp.valid && rsp.data.time_write,
		rsp.data.mode == csm_pkg::MODE_SET, "time write outside set mode")
	`CSM_ASSERT_IMPLY(a_elapsed_zero, clk, arst_n,
		rsp.valid && rsp.data.mode != csm_pkg::MODE_STOPWATCH,
		rsp.data.elapsed_minutes == '0 && rsp.data.elapsed_secs == '0,
		"elapsed time shown outside stopwatch mode")
	`CSM_ASSERT_NEXT(a_accept_fills, clk, arst_n, req.valid && req.ready, v_s1,
		"accepted event did not reach stage one")

endmodule

`default_nettype wire
